[src/gble_pkg.sv]
// gble_pkg: shared widths, payload types and helper functions for the
// grid bilinear energy lookup; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package gble_pkg;

   // grid and number formats
   localparam int CELLS_X     = 64;
   localparam int CELLS_Y     = 64;
   localparam int FRAC_BITS   = 8;
   localparam int ENERGY_BITS = 16;

   // fixed port widths
   localparam int POS_BITS    = 14;
   localparam int CORNER_BITS = 16;
   localparam int RESULT_BITS = 16;

   // derived sizes
   localparam int INT_BITS   = POS_BITS - FRAC_BITS;
   localparam int CELL_COUNT = CELLS_X * CELLS_Y;
   localparam int IDX_BITS   = $clog2(CELL_COUNT);
   localparam int FRAC_ONE   = 1 << FRAC_BITS;
   localparam int WGT_BITS   = 2 * FRAC_BITS + 1;
   localparam int PROD_BITS  = ENERGY_BITS + WGT_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 2;

   // queue between front and back
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef logic signed [ENERGY_BITS-1:0] energy_type;
   typedef logic [FRAC_BITS-1:0]          frac_type;

   // one table entry, packed as stored in the ram
   typedef struct packed {
      energy_type ur;
      energy_type ul;
      energy_type lr;
      energy_type ll;
   } cell_type;

   localparam int CELL_BITS = $bits(cell_type);

   // one beat handed from front to back
   typedef struct packed {
      logic     kind;
      frac_type fx;
      frac_type fy;
      cell_type corners;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   // kind codes
   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // clamp a 16-bit corner into the stored energy range
   function automatic energy_type sat_energy(input logic signed [CORNER_BITS-1:0] v);
      logic signed [32:0] w;
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      w  = 33'(v);
      hi = (33'sd1 <<< (ENERGY_BITS - 1)) - 33'sd1;
      lo = -(33'sd1 <<< (ENERGY_BITS - 1));
      if (w > hi) begin
         w = hi;
      end else if (w < lo) begin
         w = lo;
      end
      return energy_type'(w);
   endfunction

   // integer parts of the position, wrapped into the grid
   function automatic logic [IDX_BITS-1:0] cell_index(input logic [POS_BITS-1:0] px,
                                                       input logic [POS_BITS-1:0] py);
      logic [INT_BITS-1:0] ix;
      logic [INT_BITS-1:0] iy;
      logic [31:0]         col;
      logic [31:0]         row;
      ix  = px[POS_BITS-1:FRAC_BITS];
      iy  = py[POS_BITS-1:FRAC_BITS];
      col = 32'(ix) % CELLS_X;
      row = 32'(iy) % CELLS_Y;
      return IDX_BITS'(row * 32'(CELLS_X) + col);
   endfunction

endpackage

`default_nettype wire

[src/gble_ram.sv]
// gble_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gble_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/gble_front.sv]
// gble_front: accepts request beats, writes or reads the corner table
// depends on gble_pkg and gble_ram
`timescale 1ns / 1ps
`default_nettype none

module gble_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_kind,
   input  wire logic [gble_pkg::POS_BITS-1:0]         req_pos_x,
   input  wire logic [gble_pkg::POS_BITS-1:0]         req_pos_y,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_low_left,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_low_right,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_up_left,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_up_right,
   input  wire logic [gble_pkg::QCNT_BITS-1:0]        q_level,
   output gble_pkg::push_type                         push
);

   logic                              accept;
   logic [gble_pkg::IDX_BITS-1:0]     ram_addr;
   gble_pkg::cell_type                ram_wdata;
   logic [gble_pkg::CELL_BITS-1:0]    ram_rdata;
   logic [gble_pkg::QCNT_BITS:0]      used;

   logic                 stage_valid_ff;
   logic                 stage_kind_ff;
   gble_pkg::frac_type   stage_fx_ff;
   gble_pkg::frac_type   stage_fy_ff;

   // room check counts the beat still waiting on the ram
   assign used      = {1'b0, q_level} + {{gble_pkg::QCNT_BITS{1'b0}}, stage_valid_ff};
   assign req_ready = !reset && (used < (gble_pkg::QCNT_BITS + 1)'(gble_pkg::QDEPTH));
   assign accept    = req_valid && req_ready;

   assign ram_addr     = gble_pkg::cell_index(req_pos_x, req_pos_y);
   assign ram_wdata.ll = gble_pkg::sat_energy(req_corner_low_left);
   assign ram_wdata.lr = gble_pkg::sat_energy(req_corner_low_right);
   assign ram_wdata.ul = gble_pkg::sat_energy(req_corner_up_left);
   assign ram_wdata.ur = gble_pkg::sat_energy(req_corner_up_right);

   gble_ram #(
      .WIDTH (gble_pkg::CELL_BITS),
      .DEPTH (gble_pkg::CELL_COUNT)
   ) u_table (
      .clock (clock),
      .we    (accept && (req_kind == gble_pkg::KIND_WRITE)),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
      if (accept) begin
         stage_kind_ff <= req_kind;
         stage_fx_ff   <= req_pos_x[gble_pkg::FRAC_BITS-1:0];
         stage_fy_ff   <= req_pos_y[gble_pkg::FRAC_BITS-1:0];
      end
   end

   always_comb begin
      push.valid        = stage_valid_ff;
      push.item.kind    = stage_kind_ff;
      push.item.fx      = stage_fx_ff;
      push.item.fy      = stage_fy_ff;
      push.item.corners = gble_pkg::cell_type'(ram_rdata);
   end

endmodule

`default_nettype wire

[src/gble_queue.sv]
// gble_queue: short fifo between front and back
// depends on gble_pkg
`timescale 1ns / 1ps
`default_nettype none

module gble_queue (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gble_pkg::push_type             push,
   input  wire logic                           pop,
   output logic                                head_valid,
   output gble_pkg::item_type                  head_item,
   output logic [gble_pkg::QCNT_BITS-1:0]      level
);

   gble_pkg::item_type                  slot_ff [gble_pkg::QDEPTH];
   logic [gble_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gble_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gble_pkg::QCNT_BITS-1:0]      count_ff,  count_in;
   logic                                do_pop;

   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign level      = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

[src/gble_back.sv]
// gble_back: weight, multiply and round pipeline with the result register
// depends on gble_pkg
`timescale 1ns / 1ps
`default_nettype none

module gble_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                head_valid,
   input  wire gble_pkg::item_type                  head_item,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [gble_pkg::RESULT_BITS-1:0]  rsp_energy,
   output logic                                     rsp_was_write
);

   localparam int W  = gble_pkg::WGT_BITS;
   localparam int P  = gble_pkg::PROD_BITS;
   localparam int SB = gble_pkg::SUM_BITS;
   localparam logic signed [SB-1:0] ROUND_HALF = SB'(1) <<< (2 * gble_pkg::FRAC_BITS - 1);

   logic adv;

   // stage 1: weights
   logic [gble_pkg::FRAC_BITS:0] gx, gy, fx, fy;
   logic [W-1:0] w_ll_in, w_lr_in, w_ul_in, w_ur_in;
   logic [W-1:0] w_ll_ff, w_lr_ff, w_ul_ff, w_ur_ff;
   logic               s1_valid_ff;
   logic               s1_kind_ff;
   gble_pkg::cell_type s1_cell_ff;

   // stage 2: products
   logic signed [P-1:0] p_ll_in, p_lr_in, p_ul_in, p_ur_in;
   logic signed [P-1:0] p_ll_ff, p_lr_ff, p_ul_ff, p_ur_ff;
   logic s2_valid_ff;
   logic s2_kind_ff;

   // stage 3: sum, round, result register
   logic signed [SB-1:0] sum;
   logic signed [SB-1:0] shifted;
   logic signed [gble_pkg::RESULT_BITS-1:0] energy_in;
   logic rsp_valid_ff;
   logic rsp_was_write_ff;
   logic signed [gble_pkg::RESULT_BITS-1:0] rsp_energy_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   always_comb begin
      fx = {1'b0, head_item.fx};
      fy = {1'b0, head_item.fy};
      gx = (gble_pkg::FRAC_BITS + 1)'(gble_pkg::FRAC_ONE) - fx;
      gy = (gble_pkg::FRAC_BITS + 1)'(gble_pkg::FRAC_ONE) - fy;
      w_ll_in = W'(gx) * W'(gy);
      w_lr_in = W'(fx) * W'(gy);
      w_ul_in = W'(gx) * W'(fy);
      w_ur_in = W'(fx) * W'(fy);
   end

   always_comb begin
      p_ll_in = P'(s1_cell_ff.ll) * P'($signed({1'b0, w_ll_ff}));
      p_lr_in = P'(s1_cell_ff.lr) * P'($signed({1'b0, w_lr_ff}));
      p_ul_in = P'(s1_cell_ff.ul) * P'($signed({1'b0, w_ul_ff}));
      p_ur_in = P'(s1_cell_ff.ur) * P'($signed({1'b0, w_ur_ff}));
   end

   always_comb begin
      sum = SB'(p_ll_ff) + SB'(p_lr_ff) + SB'(p_ul_ff) + SB'(p_ur_ff) + ROUND_HALF;
      // arithmetic shift gives the floor
      shifted = sum >>> (2 * gble_pkg::FRAC_BITS);
      if (s2_kind_ff == gble_pkg::KIND_WRITE) begin
         energy_in = '0;
      end else begin
         energy_in = gble_pkg::RESULT_BITS'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s1_kind_ff       <= head_item.kind;
         s1_cell_ff       <= head_item.corners;
         w_ll_ff          <= w_ll_in;
         w_lr_ff          <= w_lr_in;
         w_ul_ff          <= w_ul_in;
         w_ur_ff          <= w_ur_in;
         s2_kind_ff       <= s1_kind_ff;
         p_ll_ff          <= p_ll_in;
         p_lr_ff          <= p_lr_in;
         p_ul_ff          <= p_ul_in;
         p_ur_ff          <= p_ur_in;
         rsp_was_write_ff <= s2_kind_ff;
         rsp_energy_ff    <= energy_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = rsp_energy_ff;
   assign rsp_was_write = rsp_was_write_ff;

endmodule

`default_nettype wire

[src/grid_bilinear_energy_lookup.sv]
// grid_bilinear_energy_lookup: top level joining front, queue and back
// depends on gble_pkg, gble_front, gble_queue and gble_back
//
// A 64 x 64 grid of cells, each holding four signed corner energies, kept in
// one single-port 4096 x 64 ram. A write beat (kind 1) stores the four corners
// of the cell picked by the integer parts of pos_x / pos_y (6.8 fixed point,
// integer parts wrap around the grid; corners are clamped to the energy
// range). A query beat (kind 0) returns the bilinear blend of that cell's
// corners, weighted by the 8-bit fractions and rounded to nearest, ties toward
// plus infinity. Every beat gives exactly one result beat, in order; writes
// answer energy 0 with was_write set. The table is not cleared at reset:
// querying a cell before writing it returns an undefined value, and no
// clearing pass is made. Throughput is one beat per clock while result
// beats are taken, set by the one ram access per beat and the fully
// pipelined weight and multiply stages. From accept to result valid a
// beat passes ram read at accept, then queue, weights, products, and sum
// and round into the result register. req_ready is low while reset is high.
`timescale 1ns / 1ps
`default_nettype none

module grid_bilinear_energy_lookup (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_kind,
   input  wire logic [gble_pkg::POS_BITS-1:0]           req_pos_x,
   input  wire logic [gble_pkg::POS_BITS-1:0]           req_pos_y,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_low_left,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_low_right,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_up_left,
   input  wire logic signed [gble_pkg::CORNER_BITS-1:0] req_corner_up_right,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [gble_pkg::RESULT_BITS-1:0]      rsp_energy,
   output logic                                         rsp_was_write
);

   // front to queue: one beat per cycle while the room check lets beats in, in the cycle after accept
   gble_pkg::push_type                push;
   // queue fill level, used by the front for its room check
   logic [gble_pkg::QCNT_BITS-1:0]    q_level;
   // queue head toward the back
   logic                              head_valid;
   gble_pkg::item_type                head_item;
   logic                              pop;

   gble_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_corner_low_left  (req_corner_low_left),
      .req_corner_low_right (req_corner_low_right),
      .req_corner_up_left   (req_corner_up_left),
      .req_corner_up_right  (req_corner_up_right),
      .q_level              (q_level),
      .push                 (push)
   );

   // decouples the ram side from result back-pressure
   gble_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .level      (q_level)
   );

   // back pipeline stalls as a whole while the result beat is not taken
   gble_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_energy    (rsp_energy),
      .rsp_was_write (rsp_was_write)
   );

endmodule

`default_nettype wire

[sim/grid_bilinear_energy_lookup_test.sv]
// grid_bilinear_energy_lookup_test: self-checking bench for the grid bilinear
// energy lookup; needs gble_pkg and the grid_bilinear_energy_lookup rtl only
`timescale 1ns / 1ps

module grid_bilinear_energy_lookup_test;

   // grid geometry and number formats, all taken from the package
   localparam int POS_W    = gble_pkg::POS_BITS;
   localparam int FRAC_W   = gble_pkg::FRAC_BITS;
   localparam int CORNER_W = gble_pkg::CORNER_BITS;
   localparam int RESULT_W = gble_pkg::RESULT_BITS;
   localparam int GRID_X   = gble_pkg::CELLS_X;
   localparam int GRID_Y   = gble_pkg::CELLS_Y;
   localparam int TILES    = GRID_X * GRID_Y;
   localparam int UNIT     = 1 << FRAC_W;
   localparam int WHOLE_MAX = (1 << gble_pkg::INT_BITS) - 1;

   // run control
   localparam int SETTLE      = 12;      // a margin past the pipe plus queue
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_PRINTED = 40;
   localparam int RANDOM_BEATS = 600;

   typedef logic signed [CORNER_W-1:0] corner_word_type;

   localparam corner_word_type TOP_ENERGY = {1'b0, {(CORNER_W-1){1'b1}}};
   localparam corner_word_type BOT_ENERGY = {1'b1, {(CORNER_W-1){1'b0}}};

   // corners as held in the table, kept wide for the blend arithmetic
   typedef struct {
      longint ll;
      longint lr;
      longint ul;
      longint ur;
   } corner_set_type;

   typedef struct {
      logic signed [RESULT_W-1:0] energy;
      logic                       was_write;
   } result_beat_type;

   // dut ports, every input known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = gble_pkg::KIND_QUERY;
   logic [POS_W-1:0]     req_pos_x = '0;
   logic [POS_W-1:0]     req_pos_y = '0;
   corner_word_type      req_corner_low_left = '0;
   corner_word_type      req_corner_low_right = '0;
   corner_word_type      req_corner_up_left = '0;
   corner_word_type      req_corner_up_right = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_energy;
   logic                 rsp_was_write;

   // predictor state: shadow of the corner table and which tiles hold data
   corner_set_type  corner_store [TILES];
   bit              tile_written [TILES];
   int              written_tiles [$];
   result_beat_type awaited_results [$];
   result_beat_type arrived_want;

   // sender burst bookkeeping and receiver stall pattern
   int           burst_left = 0;
   logic [15:0]  stall_pattern = 16'hFFFF;
   int           cycle_count = 0;

   // tallies
   int           error_count = 0;
   int           writes_sent = 0;
   int           queries_sent = 0;

   grid_bilinear_energy_lookup DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_corner_low_left  (req_corner_low_left),
      .req_corner_low_right (req_corner_low_right),
      .req_corner_up_left   (req_corner_up_left),
      .req_corner_up_right  (req_corner_up_right),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_energy           (rsp_energy),
      .rsp_was_write        (rsp_was_write)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // corner is sign-extended, then clamped into the stored energy range
   function automatic longint clamp_to_energy(input corner_word_type v);
      longint lim;
      longint w;
      lim = longint'(1) << (gble_pkg::ENERGY_BITS - 1);
      w   = longint'(v);
      if (w > lim - 1) begin
         w = lim - 1;
      end else if (w < -lim) begin
         w = -lim;
      end
      return w;
   endfunction

   // integer parts pick the tile, wrapping around the grid
   function automatic int tile_of(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
      int col;
      int row;
      col = int'(px >> FRAC_W) % GRID_X;
      row = int'(py >> FRAC_W) % GRID_Y;
      return row * GRID_X + col;
   endfunction

   // weighted corner sum over UNIT^2, rounded to nearest with ties going up;
   // >>> on a signed longint is a floor, which gives the tie direction
   function automatic logic signed [RESULT_W-1:0] blend_energy(input corner_set_type c,
                                                               input int fx, input int fy);
      longint gx;
      longint gy;
      longint sum;
      longint rounded;
      gx  = UNIT - fx;
      gy  = UNIT - fy;
      sum = c.ll * gx * gy + c.lr * fx * gy + c.ul * gx * fy + c.ur * fx * fy;
      rounded = (sum + (longint'(UNIT) * UNIT / 2)) >>> (2 * FRAC_W);
      return rounded[RESULT_W-1:0];
   endfunction

   // update the shadow table for one accepted beat and queue its result
   task automatic apply_beat(input logic kind,
                             input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                             input corner_word_type ll, input corner_word_type lr,
                             input corner_word_type ul, input corner_word_type ur);
      int              tile;
      result_beat_type want;
      tile = tile_of(px, py);
      if (kind == gble_pkg::KIND_WRITE) begin
         corner_store[tile].ll = clamp_to_energy(ll);
         corner_store[tile].lr = clamp_to_energy(lr);
         corner_store[tile].ul = clamp_to_energy(ul);
         corner_store[tile].ur = clamp_to_energy(ur);
         if (!tile_written[tile]) begin
            tile_written[tile] = 1'b1;
            written_tiles.push_back(tile);
         end
         want.energy    = '0;
         want.was_write = 1'b1;
         writes_sent++;
      end else begin
         want.energy    = blend_energy(corner_store[tile], int'(px[FRAC_W-1:0]),
                                       int'(py[FRAC_W-1:0]));
         want.was_write = 1'b0;
         queries_sent++;
      end
      awaited_results.push_back(want);
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("%0t ns  mismatch: %s", $time, what);
      end
   endtask

   // every accepted result beat is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing awaited (energy %0d)",
                                      rsp_energy));
         end else begin
            arrived_want = awaited_results.pop_front();
            if (rsp_energy !== arrived_want.energy) begin
               report_mismatch($sformatf("energy %0d, predicted %0d", rsp_energy,
                                         arrived_want.energy));
            end
            if (rsp_was_write !== arrived_want.was_write) begin
               report_mismatch($sformatf("was_write %b, predicted %b", rsp_was_write,
                                         arrived_want.was_write));
            end
         end
      end
   end

   // receiver stalls from a 16-bit pattern redrawn per window; a quarter
   // of the windows never stall, the rest always keep at least one ready slot
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count % 100 == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            stall_pattern = 16'hFFFF;
         end else begin
            stall_pattern = 16'($urandom) | 16'h0001;
         end
      end
      rsp_ready <= stall_pattern[cycle_count % 16];
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_results.size());
         $display("grid_bilinear_energy_lookup_test: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // drive one beat and hold it until accepted; bursts of random length are
   // broken up by random gaps, so idle cycles land at every pipeline phase
   task automatic send_beat(input logic kind,
                            input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input corner_word_type ll, input corner_word_type lr,
                            input corner_word_type ul, input corner_word_type ur);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid            <= 1'b1;
      req_kind             <= kind;
      req_pos_x            <= px;
      req_pos_y            <= py;
      req_corner_low_left  <= ll;
      req_corner_low_right <= lr;
      req_corner_up_left   <= ul;
      req_corner_up_right  <= ur;
      do @(posedge clock); while (!req_ready);
      apply_beat(kind, px, py, ll, lr, ul, ur);
   endtask

   // drop valid, let every predicted result come back, then let the pipe settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // position whose integer part lands on the given column or row, using any
   // alias the wrap allows, with the given fraction
   function automatic logic [POS_W-1:0] pos_for(input int index, input int cells,
                                                input int frac);
      int whole;
      whole = index + cells * $urandom_range(0, (WHOLE_MAX - index) / cells);
      return POS_W'((whole << FRAC_W) | frac);
   endfunction

   function automatic int pick_frac();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return UNIT - 1;
         2:       return UNIT / 2;
         default: return $urandom_range(0, UNIT - 1);
      endcase
   endfunction

   function automatic corner_word_type pick_corner();
      case ($urandom_range(0, 7))
         0:       return TOP_ENERGY;
         1:       return BOT_ENERGY;
         2:       return CORNER_W'(int'($urandom_range(0, 64)) - 32);
         default: return CORNER_W'($urandom);
      endcase
   endfunction

   task automatic write_tile(input int tile, input corner_word_type ll,
                             input corner_word_type lr, input corner_word_type ul,
                             input corner_word_type ur);
      send_beat(gble_pkg::KIND_WRITE,
                pos_for(tile % GRID_X, GRID_X, $urandom_range(0, UNIT - 1)),
                pos_for(tile / GRID_X, GRID_Y, $urandom_range(0, UNIT - 1)),
                ll, lr, ul, ur);
   endtask

   // corner ports carry junk on queries, the block must ignore them
   task automatic query_tile(input int tile, input int fx, input int fy);
      send_beat(gble_pkg::KIND_QUERY,
                pos_for(tile % GRID_X, GRID_X, fx), pos_for(tile / GRID_X, GRID_Y, fy),
                pick_corner(), pick_corner(), pick_corner(), pick_corner());
   endtask

   // one random step: a fresh write anywhere, a rewrite followed at once by a
   // lookup of the same tile, or a lookup of any tile holding data
   task automatic random_step();
      int pick;
      int tile;
      pick = $urandom_range(0, 99);
      if (written_tiles.size() == 0 || pick < 20) begin
         send_beat(gble_pkg::KIND_WRITE, POS_W'($urandom), POS_W'($urandom),
                   pick_corner(), pick_corner(), pick_corner(), pick_corner());
      end else begin
         tile = written_tiles[$urandom_range(0, written_tiles.size() - 1)];
         if (pick < 32) begin
            write_tile(tile, pick_corner(), pick_corner(), pick_corner(), pick_corner());
         end
         query_tile(tile, pick_frac(), pick_frac());
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // full-scale corners, mixed signs, grid corners and the top position
   task automatic test_corner_extremes();
      int far_tile;
      far_tile = TILES - 1;
      write_tile(0, TOP_ENERGY, TOP_ENERGY, TOP_ENERGY, TOP_ENERGY);
      write_tile(far_tile, BOT_ENERGY, BOT_ENERGY, BOT_ENERGY, BOT_ENERGY);
      write_tile(1, TOP_ENERGY, BOT_ENERGY, BOT_ENERGY, TOP_ENERGY);
      write_tile(GRID_X, -16'sd1, 16'sd0, 16'sd1, BOT_ENERGY);
      query_tile(0, 0, 0);
      query_tile(0, UNIT - 1, UNIT - 1);
      query_tile(far_tile, UNIT - 1, UNIT - 1);
      query_tile(far_tile, 0, 0);
      query_tile(1, UNIT / 2, UNIT / 2);
      query_tile(1, UNIT - 1, 0);
      query_tile(GRID_X, 0, UNIT - 1);
      query_tile(GRID_X, UNIT / 2, UNIT / 3);
   endtask

   // exact halfway sums on both signs, just either side of a tie, and a
   // lookup issued right behind the write that changes its tile
   task automatic test_rounding_ties();
      int tile_a;
      int tile_b;
      tile_a = 9 * GRID_X + 5;
      tile_b = 3 * GRID_X + 2;
      write_tile(tile_a, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
      query_tile(tile_a, UNIT / 2, 0);
      write_tile(tile_b, 16'sd0, -16'sd1, 16'sd0, 16'sd0);
      query_tile(tile_b, UNIT / 2, 0);
      query_tile(tile_b, UNIT / 2 + 1, 0);
      query_tile(tile_b, UNIT / 2 - 1, 0);
      write_tile(tile_a, BOT_ENERGY, TOP_ENERGY, 16'sd7, -16'sd7);
      query_tile(tile_a, 0, 0);
   endtask

   // the sender holds off until the pipe is empty, then restarts cold
   task automatic test_drain_pause();
      repeat (20) random_step();
      wait_quiet();
      repeat (20) random_step();
      wait_quiet();
   endtask

   task automatic test_random_mix(input int beats);
      int target;
      target = writes_sent + queries_sent + beats;
      while (writes_sent + queries_sent < target) random_step();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_corner_extremes();
      test_rounding_ties();
      test_drain_pause();
      test_random_mix(RANDOM_BEATS);
      wait_quiet();
      $display("covered %0d table writes and %0d blended lookups in %0d cycles,",
               writes_sent, queries_sent, cycle_count);
      $display("with full-scale corners, rounding ties, rewrite-then-read and a drain pause");
      if (error_count == 0) begin
         $display("grid_bilinear_energy_lookup_test: clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("grid_bilinear_energy_lookup_test: errors");
      end
      $finish;
   end

endmodule

[sim.f]
src/gble_pkg.sv
src/gble_ram.sv
src/gble_front.sv
src/gble_queue.sv
src/gble_back.sv
src/grid_bilinear_energy_lookup.sv
sim/grid_bilinear_energy_lookup_test.sv
